// ----- sv/slcp_pkg.sv -----
// shared types and constants for the serial layer command parser
`default_nettype none

package slcp_pkg;

  localparam int LINE_LIMIT_DEFAULT = 32;
  localparam int LAYER_COUNT        = 32;
  localparam int MASK_W             = 32;
  localparam int DIGIT_W            = 4;
  localparam int CFG_INDEX_W        = 2;
  localparam int REPLY_IDX_W        = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_DIGIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BAD_CMD_DIGIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OVERFLOW_DIGIT = 2'd2;

  localparam logic [DIGIT_W-1:0] FRAME_DIGIT_RESET    = 4'd1;
  localparam logic [DIGIT_W-1:0] BAD_CMD_DIGIT_RESET  = 4'd3;
  localparam logic [DIGIT_W-1:0] OVERFLOW_DIGIT_RESET = 4'd4;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_K     = 8'h4b;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_L     = 8'h4c;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_O     = 8'h4f;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  localparam logic [8:0] NUMBER_MAX = 9'd255;

  typedef enum logic [2:0] {
    PH_K,
    PH_B,
    PH_L,
    PH_OP,
    PH_NUM
  } phase_t;

  typedef enum logic {
    REPLY_OK,
    REPLY_ERR
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t         kind;
    logic [DIGIT_W-1:0]  digit;
    logic [MASK_W-1:0]   mask;
  } reply_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] frame_digit;
    logic [DIGIT_W-1:0] bad_cmd_digit;
    logic [DIGIT_W-1:0] overflow_digit;
  } err_digits_t;

endpackage

`default_nettype wire

// ----- sv/slcp_parser.sv -----
// line parser: keeps per-line fields and the layer mask, decides each reply
`default_nettype none

module slcp_parser #(
  parameter int LINE_LIMIT = slcp_pkg::LINE_LIMIT_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire [7:0]            rx_byte,
  input  wire slcp_pkg::err_digits_t digits,
  output logic                 reply_valid,
  output slcp_pkg::reply_t     reply
);

  localparam int LEN_W = $clog2(LINE_LIMIT + 1);

  logic [LEN_W-1:0]  line_length, line_length_next;
  slcp_pkg::phase_t  parse_phase, parse_phase_next;
  logic              frame_bad, frame_bad_next;
  logic              command_bad, command_bad_next;
  logic [7:0]        operation_char, operation_char_next;
  logic [8:0]        number_value, number_value_next;
  logic [slcp_pkg::MASK_W-1:0] layer_bits, layer_bits_next, layer_bit;
  logic [11:0]       number_sum;
  logic              is_term, op_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      parse_phase    <= slcp_pkg::PH_K;
      frame_bad      <= 1'b0;
      command_bad    <= 1'b0;
      operation_char <= '0;
      number_value   <= '0;
      layer_bits     <= '0;
    end else if (accept) begin
      line_length    <= line_length_next;
      parse_phase    <= parse_phase_next;
      frame_bad      <= frame_bad_next;
      command_bad    <= command_bad_next;
      operation_char <= operation_char_next;
      number_value   <= number_value_next;
      layer_bits     <= layer_bits_next;
    end
  end

  always_comb begin
    is_term = (rx_byte == slcp_pkg::CHAR_LF) || (rx_byte == slcp_pkg::CHAR_CR);
    op_ok = (operation_char == slcp_pkg::CHAR_S) || (operation_char == slcp_pkg::CHAR_R) ||
            (operation_char == slcp_pkg::CHAR_T);
    number_sum = 12'({3'b000, number_value} * 12'd10) + 12'(rx_byte - slcp_pkg::CHAR_0);
    layer_bit = slcp_pkg::MASK_W'(1) << number_value[4:0];

    line_length_next    = line_length;
    parse_phase_next    = parse_phase;
    frame_bad_next      = frame_bad;
    command_bad_next    = command_bad;
    operation_char_next = operation_char;
    number_value_next   = number_value;
    layer_bits_next     = layer_bits;
    reply_valid         = 1'b0;
    reply.kind          = slcp_pkg::REPLY_ERR;
    reply.digit         = digits.bad_cmd_digit;

    if (is_term) begin
      if (line_length != '0) begin
        reply_valid = 1'b1;
        priority if (line_length < LEN_W'(3) || frame_bad) begin
          reply.digit = digits.frame_digit;
        end else if (command_bad || line_length < LEN_W'(5) || !op_ok) begin
          reply.digit = digits.bad_cmd_digit;
        end else begin
          reply.kind = slcp_pkg::REPLY_OK;
          if (number_value < 9'(slcp_pkg::LAYER_COUNT) && number_value < 9'd32) begin
            priority if (operation_char == slcp_pkg::CHAR_S) begin
              layer_bits_next = layer_bits | layer_bit;
            end else if (operation_char == slcp_pkg::CHAR_R) begin
              layer_bits_next = layer_bits & ~layer_bit;
            end else begin
              layer_bits_next = layer_bits ^ layer_bit;
            end
          end
        end
      end
      line_length_next    = '0;
      parse_phase_next    = slcp_pkg::PH_K;
      frame_bad_next      = 1'b0;
      command_bad_next    = 1'b0;
      operation_char_next = '0;
      number_value_next   = '0;
    end else begin
      line_length_next = line_length + LEN_W'(1);
      unique case (parse_phase)
        slcp_pkg::PH_K: begin
          if (rx_byte != slcp_pkg::CHAR_K) frame_bad_next = 1'b1;
          parse_phase_next = slcp_pkg::PH_B;
        end
        slcp_pkg::PH_B: begin
          if (rx_byte != slcp_pkg::CHAR_B) frame_bad_next = 1'b1;
          parse_phase_next = slcp_pkg::PH_L;
        end
        slcp_pkg::PH_L: begin
          if (rx_byte != slcp_pkg::CHAR_L) command_bad_next = 1'b1;
          parse_phase_next = slcp_pkg::PH_OP;
        end
        slcp_pkg::PH_OP: begin
          operation_char_next = rx_byte;
          parse_phase_next    = slcp_pkg::PH_NUM;
        end
        default: begin
          if (!command_bad) begin
            if (rx_byte < slcp_pkg::CHAR_0 || rx_byte > slcp_pkg::CHAR_9) begin
              command_bad_next  = 1'b1;
              number_value_next = '0;
            end else if (number_sum > 12'(slcp_pkg::NUMBER_MAX)) begin
              command_bad_next  = 1'b1;
              number_value_next = '0;
            end else begin
              number_value_next = number_sum[8:0];
            end
          end
        end
      endcase
      // line full without terminator: drop it and report overflow
      if (line_length_next >= LEN_W'(LINE_LIMIT)) begin
        reply_valid         = 1'b1;
        reply.digit         = digits.overflow_digit;
        line_length_next    = '0;
        parse_phase_next    = slcp_pkg::PH_K;
        frame_bad_next      = 1'b0;
        command_bad_next    = 1'b0;
        operation_char_next = '0;
        number_value_next   = '0;
      end
    end
    reply.mask = layer_bits_next;
  end

endmodule

`default_nettype wire

// ----- sv/slcp_reply.sv -----
// reply serialiser: one pending reply slot and the byte sender
`default_nettype none

module slcp_reply (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 new_valid,
  input  wire slcp_pkg::reply_t new_reply,
  output logic                slot_free,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [slcp_pkg::MASK_W-1:0] out_mask
);

  logic                           pend_valid;
  slcp_pkg::reply_t               pend;
  logic                           active;
  slcp_pkg::reply_t               cur;
  logic [slcp_pkg::REPLY_IDX_W-1:0] idx;
  logic                           load_slot;

  assign slot_free = !pend_valid;
  assign load_slot = !active || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      active     <= 1'b0;
      idx        <= '0;
    end else begin
      if (pend_valid) begin
        if (load_slot) begin
          active     <= 1'b1;
          cur        <= pend;
          idx        <= '0;
          pend_valid <= 1'b0;
        end else if (out_ready) begin
          idx <= idx + 1'b1;
        end
      end else if (new_valid) begin
        if (load_slot) begin
          active <= 1'b1;
          cur    <= new_reply;
          idx    <= '0;
        end else begin
          pend       <= new_reply;
          pend_valid <= 1'b1;
          if (out_ready) idx <= idx + 1'b1;
        end
      end else if (load_slot) begin
        active <= 1'b0;
        idx    <= '0;
      end else if (out_ready) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid = active;
    out_mask  = cur.mask;
    out_last  = 1'b0;
    out_byte  = slcp_pkg::CHAR_LF;
    unique case (cur.kind)
      slcp_pkg::REPLY_OK: begin
        unique case (idx)
          3'd0:    out_byte = slcp_pkg::CHAR_O;
          3'd1:    out_byte = slcp_pkg::CHAR_K;
          default: begin
            out_byte = slcp_pkg::CHAR_LF;
            out_last = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    out_byte = slcp_pkg::CHAR_E;
          3'd1:    out_byte = slcp_pkg::CHAR_R;
          3'd2:    out_byte = slcp_pkg::CHAR_R;
          3'd3:    out_byte = slcp_pkg::CHAR_COLON;
          3'd4:    out_byte = slcp_pkg::CHAR_0 + {4'b0000, cur.digit};
          default: begin
            out_byte = slcp_pkg::CHAR_LF;
            out_last = 1'b1;
          end
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/serial_layer_command_parser_core.sv -----
// top level of the serial layer command parser
//
//  channel  dir  fields                                  handshake
//  s_*      in   tdata[7:0] rx_byte                      tvalid/tready
//  m_*      out  tdata[7:0] reply_byte, [39:8] mask,     tvalid/tready
//                tlast reply_last
//  cfg_*    in   cfg_index, cfg_data (4-bit code digit)  cfg_we, no wait
//
// a received word is parsed in the cycle it is accepted; a reply is sent one
// word per ready cycle (OK 3 words, ERR 6), so the output drain sets the
// sustained rate for bytes that end a line. bytes that cause no reply go at
// one a cycle. s_tready drops only while a second reply waits behind the one
// being sent. reset is synchronous: empty line, no layers, default digits.
`default_nettype none

module serial_layer_command_parser_core #(
  parameter int LINE_LIMIT = slcp_pkg::LINE_LIMIT_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [39:0] m_tdata,  // [7:0] reply_byte, [39:8] layer_mask
  output logic       m_tlast,
  input  wire        cfg_we,
  input  wire [slcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [slcp_pkg::DIGIT_W-1:0]     cfg_data
);

  slcp_pkg::err_digits_t digits;
  logic                  accept;
  logic                  new_valid;
  slcp_pkg::reply_t      new_reply;
  logic [7:0]            out_byte;
  logic [slcp_pkg::MASK_W-1:0] out_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      digits.frame_digit    <= slcp_pkg::FRAME_DIGIT_RESET;
      digits.bad_cmd_digit  <= slcp_pkg::BAD_CMD_DIGIT_RESET;
      digits.overflow_digit <= slcp_pkg::OVERFLOW_DIGIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slcp_pkg::CFG_FRAME_DIGIT:    digits.frame_digit    <= cfg_data;
        slcp_pkg::CFG_BAD_CMD_DIGIT:  digits.bad_cmd_digit  <= cfg_data;
        slcp_pkg::CFG_OVERFLOW_DIGIT: digits.overflow_digit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  slcp_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .digits     (digits),
    .reply_valid(new_valid),
    .reply      (new_reply)
  );

  slcp_reply u_reply (
    .clk      (clk),
    .rst      (rst),
    .new_valid(accept && new_valid),
    .new_reply(new_reply),
    .slot_free(s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte (out_byte),
    .out_last (m_tlast),
    .out_mask (out_mask)
  );

  assign m_tdata = {out_mask, out_byte};

  // a reply in flight keeps going and keeps its mask
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tdata[39:8]))
    else $error("reply broken off or mask changed mid-reply");

  // input stalls only with a reply on the output
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with nothing being sent");

  // every reply ends on a line feed
  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == slcp_pkg::CHAR_LF)
    else $error("reply_last on a byte other than line feed");

endmodule

`default_nettype wire
